@@ hw/rtl/sik_pkg.sv @@
// shared types, constants and the arctangent table for the swerve kinematics unit
`default_nettype none
package sik_pkg;
	localparam int COMP_W = 18;
	localparam int GUARD = 8;
	localparam int DP_W = 30;
	localparam int Z_W = 32;
	localparam int TAB_LEN = 24;
	localparam int WHEELS = 4;
	localparam logic [16:0] INV_GAIN = 17'd39797;
	localparam logic [Z_W-1:0] HALF_TURN = 32'h8000_0000;
	localparam logic CFG_HALF_LENGTH_X = 1'b0;
	localparam logic CFG_HALF_WIDTH_Y = 1'b1;

	typedef logic signed [DP_W-1:0] dp_t;
	typedef logic [Z_W-1:0] ang_t;

	typedef struct packed {
		dp_t x;
		dp_t y;
		ang_t z;
		logic zero;
	} cell_data_t;

	function automatic ang_t atan_lut(input logic [4:0] idx);
		ang_t r;
		unique case (idx)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = '0;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

@@ hw/rtl/sik_cell.sv @@
// one cordic vectoring micro-rotation, registered, with its valid bit
`default_nettype none
module sik_cell #(
	parameter int STAGE = 0
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                vld_in,
	input  wire sik_pkg::cell_data_t d_in,
	output logic                     vld_q,
	output sik_pkg::cell_data_t      d_q
);
	sik_pkg::dp_t dx, dy;
	sik_pkg::ang_t a;
	sik_pkg::cell_data_t nxt;

	always_comb begin
		dx = d_in.y >>> STAGE;
		dy = d_in.x >>> STAGE;
		a = sik_pkg::atan_lut(5'(STAGE));
		nxt = d_in;
		if (!d_in.y[sik_pkg::DP_W-1]) begin
			nxt.x = d_in.x + dx;
			nxt.y = d_in.y - dy;
			nxt.z = d_in.z + a;
		end else begin
			nxt.x = d_in.x - dx;
			nxt.y = d_in.y + dy;
			nxt.z = d_in.z - a;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/sik_chain.sv @@
// prescale, chain of cordic cells and gain / rounding stage for one wheel
`default_nettype none
module sik_chain #(
	parameter int STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        vld_in,
	input  wire logic signed [sik_pkg::COMP_W-1:0] cx,
	input  wire logic signed [sik_pkg::COMP_W-1:0] cy,
	output logic             vld_out,
	output logic [15:0]      speed,
	output logic [15:0]      angle
);
	sik_pkg::cell_data_t head;
	sik_pkg::cell_data_t d [STAGES+1];
	logic v [STAGES+1];
	logic signed [sik_pkg::COMP_W-1:0] ax, ay;
	logic signed [sik_pkg::DP_W+17:0] prod;
	logic signed [sik_pkg::DP_W+17:0] mag;
	sik_pkg::ang_t zr;

	// fold left half-plane by a half turn
	always_comb begin
		ax = cx[sik_pkg::COMP_W-1] ? -cx : cx;
		ay = cx[sik_pkg::COMP_W-1] ? -cy : cy;
		head.x = sik_pkg::DP_W'(ax) <<< sik_pkg::GUARD;
		head.y = sik_pkg::DP_W'(ay) <<< sik_pkg::GUARD;
		head.z = cx[sik_pkg::COMP_W-1] ? sik_pkg::HALF_TURN : '0;
		head.zero = (cx == '0) && (cy == '0);
	end
	assign d[0] = head;
	assign v[0] = vld_in;

	for (genvar i = 0; i < STAGES; i++) begin : g_cell
		sik_cell #(.STAGE(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v[i]), .d_in(d[i]),
			.vld_q(v[i+1]), .d_q(d[i+1])
		);
	end

	always_comb begin
		prod = sik_pkg::DP_W'(d[STAGES].x) * $signed({1'b0, sik_pkg::INV_GAIN});
		mag = (prod + (48'sd1 <<< (15 + sik_pkg::GUARD))) >>> (16 + sik_pkg::GUARD);
		zr = d[STAGES].z + 32'h0000_8000;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else if (en) begin
			vld_out <= v[STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (d[STAGES].zero) begin
				speed <= '0;
				angle <= '0;
			end else begin
				if (mag[sik_pkg::DP_W+17])
					speed <= '0;
				else if (mag > 48'sd65535)
					speed <= 16'hFFFF;
				else
					speed <= mag[15:0];
				angle <= zr[31:16];
			end
		end
	end
endmodule
`default_nettype wire

@@ hw/rtl/swerve_inverse_kinematics_unit.sv @@
// top level: swerve drive inverse kinematics with four cordic cell chains
// a request passes the product register, the wheel component register, the cordic cells and the output register
// throughput: one request per cycle while the output is not stalled, set by the fully unrolled cell chains
// the whole pipe advances when the output slot is empty or being taken
// reset: geometry registers go to 16384, all pipeline valid bits clear
// config writes are taken every cycle and apply to requests accepted afterwards
`default_nettype none
module swerve_inverse_kinematics_unit #(
	parameter int CORDIC_STAGES = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [15:0] vel_x,
	input  wire logic signed [15:0] vel_y,
	input  wire logic signed [15:0] yaw_rate,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [15:0]      fl_speed,
	output logic [15:0]      fl_angle,
	output logic [15:0]      fr_speed,
	output logic [15:0]      fr_angle,
	output logic [15:0]      rl_speed,
	output logic [15:0]      rl_angle,
	output logic [15:0]      rr_speed,
	output logic [15:0]      rr_angle,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data
);
	localparam int CW = sik_pkg::COMP_W;

	logic [15:0] hlx_q, hwy_q;
	logic en;
	// stage 1: products
	logic v_s1;
	logic signed [15:0] vx_s1, vy_s1;
	logic signed [32:0] ptx_s1, pty_s1;
	// stage 2: wheel components
	logic v_s2;
	logic signed [CW-1:0] wx_s2 [sik_pkg::WHEELS];
	logic signed [CW-1:0] wy_s2 [sik_pkg::WHEELS];
	logic signed [CW-1:0] tx, ty, vxe, vye;
	logic vo [sik_pkg::WHEELS];
	logic [15:0] spd [sik_pkg::WHEELS];
	logic [15:0] ang [sik_pkg::WHEELS];

	// pipe moves whenever the output slot can take a new result
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vo[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hlx_q <= 16'd16384;
			hwy_q <= 16'd16384;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				sik_pkg::CFG_HALF_LENGTH_X: hlx_q <= cfg_data;
				sik_pkg::CFG_HALF_WIDTH_Y: hwy_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	// yaw contribution products, one 16x17 multiply each
	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= vel_x;
			vy_s1 <= vel_y;
			ptx_s1 <= yaw_rate * $signed({1'b0, hwy_q});
			pty_s1 <= yaw_rate * $signed({1'b0, hlx_q});
		end
	end

	// floor shift by 16 then the four sign combinations: fl fr rl rr
	always_comb begin
		tx = CW'(ptx_s1 >>> 16);
		ty = CW'(pty_s1 >>> 16);
		vxe = CW'(vx_s1);
		vye = CW'(vy_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s2[0] <= vxe - tx; wy_s2[0] <= vye + ty;
			wx_s2[1] <= vxe + tx; wy_s2[1] <= vye + ty;
			wx_s2[2] <= vxe - tx; wy_s2[2] <= vye - ty;
			wx_s2[3] <= vxe + tx; wy_s2[3] <= vye - ty;
		end
	end

	for (genvar w = 0; w < sik_pkg::WHEELS; w++) begin : g_wheel
		sik_chain #(.STAGES(CORDIC_STAGES)) u_chain (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_in(v_s2),
			.cx(wx_s2[w]), .cy(wy_s2[w]),
			.vld_out(vo[w]), .speed(spd[w]), .angle(ang[w])
		);
	end

	assign fl_speed = spd[0];
	assign fl_angle = ang[0];
	assign fr_speed = spd[1];
	assign fr_angle = ang[1];
	assign rl_speed = spd[2];
	assign rl_angle = ang[2];
	assign rr_speed = spd[3];
	assign rr_angle = ang[3];

	// all four chains carry the same request in lockstep
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(vo[0] == vo[1]) && (vo[1] == vo[2]) && (vo[2] == vo[3]))
		else $error("wheel chains out of step");
	// a held result stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(fl_speed) && $stable(rr_angle))
		else $error("stalled result changed");
	// stalled pipe accepts nothing
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request taken during stall");
endmodule
`default_nettype wire

@@ dv/swerve_inverse_kinematics_unit_tb.sv @@
// self-checking testbench for the swerve drive inverse kinematics unit
`timescale 1ns / 1ps
`default_nettype none
module swerve_inverse_kinematics_unit_tb;
	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 3;

	typedef struct packed {
		logic signed [15:0] vx;
		logic signed [15:0] vy;
		logic signed [15:0] wz;
	} command_t;

	typedef struct packed {
		logic [15:0] fl_spd;
		logic [15:0] fl_ang;
		logic [15:0] fr_spd;
		logic [15:0] fr_ang;
		logic [15:0] rl_spd;
		logic [15:0] rl_ang;
		logic [15:0] rr_spd;
		logic [15:0] rr_ang;
	} wheel_set_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [15:0] vel_x;
	logic signed [15:0] vel_y;
	logic signed [15:0] yaw_rate;
	logic out_valid;
	logic out_ready;
	logic [15:0] fl_speed, fl_angle, fr_speed, fr_angle;
	logic [15:0] rl_speed, rl_angle, rr_speed, rr_angle;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_index;
	logic [15:0] cfg_data;

	swerve_inverse_kinematics_unit #(.CORDIC_STAGES(STAGES)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.vel_x(vel_x), .vel_y(vel_y), .yaw_rate(yaw_rate),
		.out_valid(out_valid), .out_ready(out_ready),
		.fl_speed(fl_speed), .fl_angle(fl_angle),
		.fr_speed(fr_speed), .fr_angle(fr_angle),
		.rl_speed(rl_speed), .rl_angle(rl_angle),
		.rr_speed(rr_speed), .rr_angle(rr_angle),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor copy of the geometry registers
	logic [15:0] geom_len_x;
	logic [15:0] geom_wid_y;

	command_t   pending_cmds[$];
	wheel_set_t expected_wheels[$];
	int mismatches;
	bit hold_requests;

	// arctangent step table, 2^32 per turn
	function automatic logic [31:0] atan_step(input int k);
		logic [31:0] t [0:23];
		t = '{32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
			32'd42667331, 32'd21354465, 32'd10679838, 32'd5340245,
			32'd2670163, 32'd1335087, 32'd667544, 32'd333772,
			32'd166886, 32'd83443, 32'd41722, 32'd20861,
			32'd10430, 32'd5215, 32'd2608, 32'd1304,
			32'd652, 32'd326, 32'd163, 32'd81};
		return t[k];
	endfunction

	// vectoring cordic on one wheel vector, gives {speed, angle}
	function automatic logic [31:0] wheel_polar(input longint wx, input longint wy);
		longint x, y, dx, dy, mag;
		logic [31:0] z;
		logic [15:0] spd;
		logic [15:0] ang;
		x = wx;
		y = wy;
		z = '0;
		if (x == 0 && y == 0)
			return '0;
		// left half-plane: pre-rotate by half a turn
		if (x < 0) begin
			x = -x;
			y = -y;
			z = 32'h8000_0000;
		end
		x = x <<< sik_pkg::GUARD;
		y = y <<< sik_pkg::GUARD;
		for (int k = 0; k < STAGES && k < 24; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				z += atan_step(k);
			end else begin
				x -= dx;
				y += dy;
				z -= atan_step(k);
			end
		end
		mag = (x * 39797 + (longint'(1) <<< (15 + sik_pkg::GUARD))) >>> (16 + sik_pkg::GUARD);
		if (mag < 0)
			mag = 0;
		if (mag > 65535)
			mag = 65535;
		spd = mag[15:0];
		// rounding may wrap a full turn back to zero
		ang = 16'((z + 32'h8000) >> 16);
		return {spd, ang};
	endfunction

	function automatic wheel_set_t predict_wheels(input command_t c);
		longint vx, vy, wz, tx, ty;
		wheel_set_t w;
		vx = c.vx;
		vy = c.vy;
		wz = c.wz;
		tx = (wz * longint'(geom_wid_y)) >>> 16;
		ty = (wz * longint'(geom_len_x)) >>> 16;
		{w.fl_spd, w.fl_ang} = wheel_polar(vx - tx, vy + ty);
		{w.fr_spd, w.fr_ang} = wheel_polar(vx + tx, vy + ty);
		{w.rl_spd, w.rl_ang} = wheel_polar(vx - tx, vy - ty);
		{w.rr_spd, w.rr_ang} = wheel_polar(vx + tx, vy - ty);
		return w;
	endfunction

	// mostly short gaps, now and then a long one, sometimes none
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// request driver, predicts at acceptance so config changes line up
	int send_gap;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			vel_x <= '0;
			vel_y <= '0;
			yaw_rate <= '0;
			send_gap <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_wheels.push_back(predict_wheels({vel_x, vel_y, yaw_rate}));
			if (!in_valid || in_ready) begin
				if (send_gap > 0 || hold_requests || pending_cmds.size() == 0) begin
					in_valid <= 1'b0;
					if (send_gap > 0)
						send_gap <= send_gap - 1;
				end else begin
					command_t c;
					c = pending_cmds.pop_front();
					in_valid <= 1'b1;
					vel_x <= c.vx;
					vel_y <= c.vy;
					yaw_rate <= c.wz;
					send_gap <= gap_len();
				end
			end
		end
	end

	// result monitor with random back-pressure
	int stall_cnt;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_cnt <= 0;
		end else begin
			if (out_valid && out_ready) begin
				wheel_set_t got, exp_w;
				got = {fl_speed, fl_angle, fr_speed, fr_angle,
					rl_speed, rl_angle, rr_speed, rr_angle};
				if (expected_wheels.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result %h", got);
				end else begin
					exp_w = expected_wheels.pop_front();
					if (got !== exp_w) begin
						mismatches++;
						if (mismatches <= 10)
							$display("wheel mismatch exp %h got %h", exp_w, got);
					end
				end
			end
			if (stall_cnt > 0) begin
				out_ready <= 1'b0;
				stall_cnt <= stall_cnt - 1;
			end else begin
				out_ready <= 1'b1;
				stall_cnt <= gap_len();
			end
		end
	end

	task automatic write_geom(input logic idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == sik_pkg::CFG_HALF_LENGTH_X)
			geom_len_x = val;
		else
			geom_wid_y = val;
	endtask

	// wait until every request came back, then let the pipe drain
	// checked at the falling edge so the driver's updates have settled
	task automatic drain();
		while (pending_cmds.size() != 0 || in_valid || expected_wheels.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_vel();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'sh7fff;
		if (r == 1)
			return 16'sh8000;
		if (r < 4)
			return 16'($urandom_range(0, 255)) - 16'sd128;
		return 16'($urandom);
	endfunction

	initial begin
		logic [15:0] geoms [0:4];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = sik_pkg::CFG_HALF_LENGTH_X;
		cfg_data = '0;
		geom_len_x = 16'd16384;
		geom_wid_y = 16'd16384;
		mismatches = 0;
		hold_requests = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, axes, zero vector, left half-plane, spin in place
		pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd0});
		pending_cmds.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff});
		pending_cmds.push_back('{16'sh8000, 16'sh8000, 16'sh8000});
		pending_cmds.push_back('{16'sh7fff, 16'sh8000, 16'sh8000});
		pending_cmds.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff});
		pending_cmds.push_back('{16'sd100, 16'sd0, 16'sd0});
		pending_cmds.push_back('{-16'sd100, 16'sd0, 16'sd0});
		pending_cmds.push_back('{16'sd0, 16'sd100, 16'sd0});
		pending_cmds.push_back('{16'sd0, -16'sd100, 16'sd0});
		pending_cmds.push_back('{-16'sd1, -16'sd1, 16'sd0});
		pending_cmds.push_back('{-16'sd1000, 16'sd1, 16'sd0});
		pending_cmds.push_back('{-16'sd1000, -16'sd1, 16'sd0});
		pending_cmds.push_back('{16'sd0, 16'sd0, 16'sd4096});
		pending_cmds.push_back('{16'sd0, 16'sd0, -16'sd1});
		pending_cmds.push_back('{16'sd1000, -16'sd1, 16'sd0});
		// hold everything until the directed set has come back
		drain();

		// geometry sweeps, extremes included; each phase writes both registers
		geoms = '{16'd0, 16'hffff, 16'd1, 16'd16384, 16'h8000};
		for (int ph = 0; ph < 6; ph++) begin
			write_geom(sik_pkg::CFG_HALF_LENGTH_X, ph < 5 ? geoms[ph] : 16'($urandom));
			write_geom(sik_pkg::CFG_HALF_WIDTH_Y, ph < 5 ? geoms[4 - ph] : 16'($urandom));
			for (int n = 0; n < 65; n++)
				pending_cmds.push_back('{rand_vel(), rand_vel(), rand_vel()});
			if (ph == 2) begin
				// sender pause until the pipe is empty mid-phase
				while (pending_cmds.size() >= 30)
					@(negedge clk);
				hold_requests = 1'b1;
				while (in_valid || expected_wheels.size() != 0)
					@(negedge clk);
				hold_requests = 1'b0;
			end
			drain();
		end
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
